// ----- src/rcwc_pkg.sv -----
// rcwc_pkg: widths, codes and saturating or shifting helpers for the reno window control core
// no dependencies; used by every other file of the block

package rcwc_pkg;

  // window format
  localparam int FRACTION_BITS = 8;
  localparam int WIN_W         = 24;
  localparam int THR_W         = 16;
  localparam int SEQ_W         = 16;
  localparam int PHASE_W       = 2;
  localparam int DUP_W         = 2;

  // quotient of 2^(2*fb) / window needs 2*fb + 1 bits
  localparam int QUO_W         = 2 * FRACTION_BITS + 1;
  // divider step counter
  localparam int DIV_CNT_W     = $clog2(QUO_W);

  // common width for intermediate sums and shifted thresholds
  localparam int CALC_A        = THR_W + FRACTION_BITS + 2;
  localparam int CALC_B        = QUO_W + 1;
  localparam int CALC_AB       = (CALC_A > CALC_B) ? CALC_A : CALC_B;
  localparam int CALC_W        = (CALC_AB > WIN_W + 1) ? CALC_AB : WIN_W + 1;

  localparam logic [WIN_W-1:0]  WIN_MAX  = {WIN_W{1'b1}};
  localparam logic [THR_W-1:0]  THR_MAX  = {THR_W{1'b1}};
  localparam logic [WIN_W-1:0]  WIN_ONE  = WIN_W'(1) << FRACTION_BITS;
  localparam logic [THR_W-1:0]  INIT_THR = THR_W'(10);
  localparam logic [THR_W-1:0]  THR_FAST = THR_W'(3);
  localparam logic [DUP_W-1:0]  DUP_LIMIT = DUP_W'(3);

  // request codes
  localparam logic REQ_ACK     = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  typedef enum logic [PHASE_W-1:0] {
    PH_SLOW  = 2'd0,
    PH_AVOID = 2'd1,
    PH_RECOV = 2'd2
  } phase_t;

  // handshake between sequencer and divider
  typedef struct packed {
    logic             start;
    logic [WIN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_sts_t;

  // clamp a wide value to the window range
  function automatic logic [WIN_W-1:0] sat_win(input logic [CALC_W-1:0] v);
    logic [WIN_W-1:0] r;
    if (v > CALC_W'(WIN_MAX)) begin
      r = WIN_MAX;
    end else begin
      r = v[WIN_W-1:0];
    end
    return r;
  endfunction

  // floor(window / 2) as an integer threshold, clamped
  function automatic logic [THR_W-1:0] half_thr(input logic [WIN_W-1:0] w);
    logic [CALC_W-1:0] h;
    logic [THR_W-1:0]  r;
    h = CALC_W'(w) >> (FRACTION_BITS + 1);
    if (h > CALC_W'(THR_MAX)) begin
      r = THR_MAX;
    end else begin
      r = h[THR_W-1:0];
    end
    return r;
  endfunction

  // integer threshold moved into window format, unclamped
  function automatic logic [CALC_W-1:0] thr_q(input logic [THR_W-1:0] t);
    return CALC_W'(t) << FRACTION_BITS;
  endfunction

endpackage

// ----- src/rcwc_in_if.sv -----
// rcwc_in_if: input channel carrying acknowledgement and timeout transactions
// depends on rcwc_pkg for field widths

interface rcwc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [rcwc_pkg::SEQ_W-1:0]  ack_number;
  logic [rcwc_pkg::SEQ_W-1:0]  seq_number;
  logic                        header_valid;

  modport source (output valid, output req_type, output ack_number,
                  output seq_number, output header_valid, input ready);
  modport sink   (input valid, input req_type, input ack_number,
                  input seq_number, input header_valid, output ready);
endinterface

// ----- src/rcwc_out_if.sv -----
// rcwc_out_if: result channel carrying window state and retransmit requests
// depends on rcwc_pkg for field widths

interface rcwc_out_if;
  logic                          valid;
  logic                          ready;
  logic [rcwc_pkg::WIN_W-1:0]    window_q8;
  logic [rcwc_pkg::THR_W-1:0]    threshold;
  logic [rcwc_pkg::PHASE_W-1:0]  phase;
  logic [rcwc_pkg::SEQ_W-1:0]    window_base;
  logic [rcwc_pkg::DUP_W-1:0]    duplicate_count;
  logic                          retransmit;
  logic [rcwc_pkg::SEQ_W-1:0]    retransmit_first;
  logic [rcwc_pkg::SEQ_W-1:0]    retransmit_last;
  logic                          ack_was_new;

  modport source (output valid, output window_q8, output threshold, output phase,
                  output window_base, output duplicate_count, output retransmit,
                  output retransmit_first, output retransmit_last,
                  output ack_was_new, input ready);
  modport sink   (input valid, input window_q8, input threshold, input phase,
                  input window_base, input duplicate_count, input retransmit,
                  input retransmit_first, input retransmit_last,
                  input ack_was_new, output ready);
endinterface

// ----- src/rcwc_div.sv -----
// rcwc_div: restoring divider, one quotient bit per cycle, for 2^(2*fb) / window
// depends on rcwc_pkg for widths and the request/status structs

module rcwc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rcwc_pkg::div_req_t req,
  output rcwc_pkg::div_sts_t sts
);
  import rcwc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIN_W-1:0]     rem_r, rem_nxt;
  logic [WIN_W-1:0]     dvs_r, dvs_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;

  logic [WIN_W:0]   trial;
  logic [WIN_W:0]   diff;
  logic             ge;

  // dividend is a single set bit at the top, so only the first step brings in a one
  always_comb begin
    trial = {rem_r, (cnt_r == '0)};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (busy_r) begin
      rem_nxt = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = '0;
      dvs_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

// ----- src/reno_congestion_window_control_core.sv -----
// reno_congestion_window_control_core: sender-side reno congestion window control
// depends on rcwc_pkg, rcwc_in_if, rcwc_out_if and rcwc_div
//
//   channel   dir  handshake          contents
//   in_ch     in   valid/ready        req_type, ack_number, seq_number, header_valid
//   out_ch    out  valid/ready        window, threshold, phase, base, dup count, retransmit
//   cfg_*     in   cfg_we, no ready   slow start threshold
//
// one transaction at a time: in_ch.ready is high only while the core is idle
// a new ack in congestion avoidance with a non-zero window goes from acceptance through the
// exec state and the bit-serial divider, whose done flag is registered, before raising out_ch.valid
// every other transaction goes from the exec state straight to the output state that raises it
// out_ch.valid holds until taken; stalls on out_ch hold off the next input transaction
// rst_n is synchronous: window 1.0, threshold 10, slow start, base and counts zero

module reno_congestion_window_control_core (
  input  logic                        clk,
  input  logic                        rst_n,
  rcwc_in_if.sink                     in_ch,
  rcwc_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [rcwc_pkg::THR_W-1:0]  cfg_wdata
);
  import rcwc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;

  // latched input transaction
  logic              req_r, req_nxt;
  logic [SEQ_W-1:0]  ack_r, ack_nxt;
  logic [SEQ_W-1:0]  seq_r, seq_nxt;
  logic              hv_r, hv_nxt;

  // window control state
  logic [WIN_W-1:0]  win_r, win_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  phase_t            phase_r, phase_nxt;
  logic [SEQ_W-1:0]  base_r, base_nxt;
  logic [DUP_W-1:0]  dup_r, dup_nxt;
  logic [SEQ_W-1:0]  gap_r, gap_nxt;

  // per-transaction result flags
  logic              rt_r, rt_nxt;
  logic [SEQ_W-1:0]  rtf_r, rtf_nxt;
  logic [SEQ_W-1:0]  rtl_r, rtl_nxt;
  logic              new_r, new_nxt;

  div_req_t          div_req;
  div_sts_t          div_sts;

  // shared helpers for the exec step
  logic [WIN_W-1:0]  win_plus_one;
  logic [THR_W-1:0]  thr_half;
  logic [DUP_W-1:0]  dup_inc;
  logic              ack_new;
  logic              need_div;

  rcwc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sts   (div_sts)
  );

  always_comb begin
    win_plus_one = sat_win(CALC_W'(win_r) + CALC_W'(WIN_ONE));
    thr_half     = half_thr(win_r);
    dup_inc      = (dup_r == DUP_LIMIT) ? DUP_LIMIT : dup_r + DUP_W'(1);
    ack_new      = (ack_r > base_r);
    // only a new ack in avoidance with a non-zero window needs the divider
    need_div     = (req_r == REQ_ACK) && hv_r && ack_new &&
                   (phase_r != PH_SLOW) && (phase_r != PH_RECOV) && (win_r != '0);
  end

  assign div_req.start   = (state_r == S_EXEC) && need_div;
  assign div_req.divisor = win_r;

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    ack_nxt   = ack_r;
    seq_nxt   = seq_r;
    hv_nxt    = hv_r;
    win_nxt   = win_r;
    thr_nxt   = thr_r;
    phase_nxt = phase_r;
    base_nxt  = base_r;
    dup_nxt   = dup_r;
    gap_nxt   = gap_r;
    rt_nxt    = rt_r;
    rtf_nxt   = rtf_r;
    rtl_nxt   = rtl_r;
    new_nxt   = new_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt   = in_ch.req_type;
          ack_nxt   = in_ch.ack_number;
          seq_nxt   = in_ch.seq_number;
          hv_nxt    = in_ch.header_valid;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        rt_nxt    = 1'b0;
        rtf_nxt   = '0;
        rtl_nxt   = '0;
        new_nxt   = 1'b0;
        state_nxt = S_OUT;
        if (req_r == REQ_TIMEOUT) begin
          // timer expiry: threshold to half the window, back to slow start, resend the gap
          thr_nxt   = thr_half;
          win_nxt   = WIN_ONE;
          dup_nxt   = '0;
          phase_nxt = PH_SLOW;
          rt_nxt    = 1'b1;
          rtf_nxt   = base_r;
          rtl_nxt   = gap_r;
        end else if (hv_r) begin
          if (ack_new) begin
            if (need_div) begin
              // avoidance growth waits for the quotient
              state_nxt = S_DIV;
            end else begin
              new_nxt  = 1'b1;
              base_nxt = base_r + SEQ_W'(1);
              dup_nxt  = '0;
              if (phase_r == PH_SLOW) begin
                win_nxt = win_plus_one;
                if (CALC_W'(win_plus_one) >= thr_q(thr_r)) begin
                  phase_nxt = PH_AVOID;
                end
              end else if (phase_r == PH_RECOV) begin
                win_nxt   = sat_win(thr_q(thr_r));
                phase_nxt = PH_AVOID;
              end else begin
                // zero window in avoidance: increment saturates
                win_nxt = WIN_MAX;
              end
            end
          end else if (phase_r == PH_RECOV) begin
            // window inflation during recovery
            win_nxt = win_plus_one;
          end else begin
            gap_nxt = seq_r;
            dup_nxt = dup_inc;
            if (dup_inc == DUP_LIMIT) begin
              // third duplicate: fast retransmit and enter recovery
              thr_nxt   = thr_half;
              win_nxt   = sat_win(thr_q(thr_half + THR_FAST) +
                                  (CALC_W'(thr_half >= THR_MAX - THR_FAST + THR_W'(1))
                                   << (THR_W + FRACTION_BITS)));
              phase_nxt = PH_RECOV;
              rt_nxt    = 1'b1;
              rtf_nxt   = base_r;
              rtl_nxt   = seq_r;
            end
          end
        end
      end

      S_DIV: begin
        if (div_sts.done) begin
          win_nxt   = sat_win(CALC_W'(win_r) + CALC_W'(div_sts.quotient));
          new_nxt   = 1'b1;
          base_nxt  = base_r + SEQ_W'(1);
          dup_nxt   = '0;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // threshold register write from the configuration port
    if (cfg_we) begin
      thr_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      win_r   <= WIN_ONE;
      thr_r   <= INIT_THR;
      phase_r <= PH_SLOW;
      base_r  <= '0;
      dup_r   <= '0;
      gap_r   <= '0;
      rt_r    <= 1'b0;
      new_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      thr_r   <= thr_nxt;
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      dup_r   <= dup_nxt;
      gap_r   <= gap_nxt;
      rt_r    <= rt_nxt;
      new_r   <= new_nxt;
    end
    req_r <= req_nxt;
    ack_r <= ack_nxt;
    seq_r <= seq_nxt;
    hv_r  <= hv_nxt;
    rtf_r <= rtf_nxt;
    rtl_r <= rtl_nxt;
  end

  // state is frozen while the result waits, but for a cfg write to the threshold, so it is shown directly
  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = (state_r == S_OUT);
  assign out_ch.window_q8        = win_r;
  assign out_ch.threshold        = thr_r;
  assign out_ch.phase            = phase_r;
  assign out_ch.window_base      = base_r;
  assign out_ch.duplicate_count  = dup_r;
  assign out_ch.retransmit       = rt_r;
  assign out_ch.retransmit_first = rtf_r;
  assign out_ch.retransmit_last  = rtl_r;
  assign out_ch.ack_was_new      = new_r;

endmodule

// ----- verif/rcwc_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// rcwc_scoreboard_pkg: window predictor and result checker for the reno window core testbench
// depends on rcwc_pkg for widths, request codes and phase codes

package rcwc_scoreboard_pkg;
  import rcwc_pkg::*;

  typedef struct packed {
    logic             req_type;
    logic [SEQ_W-1:0] ack_number;
    logic [SEQ_W-1:0] seq_number;
    logic             header_valid;
  } ack_item_t;

  typedef struct packed {
    logic [WIN_W-1:0] window_q8;
    logic [THR_W-1:0] threshold;
    phase_t           phase;
    logic [SEQ_W-1:0] window_base;
    logic [DUP_W-1:0] duplicate_count;
    logic             retransmit;
    logic [SEQ_W-1:0] retransmit_first;
    logic [SEQ_W-1:0] retransmit_last;
    logic             ack_was_new;
  } window_report_t;

  class window_scoreboard;
    logic [WIN_W-1:0] cwnd;
    logic [THR_W-1:0] ssthresh;
    phase_t           ph;
    logic [SEQ_W-1:0] base;
    logic [DUP_W-1:0] dup_cnt;
    logic [SEQ_W-1:0] gap_pos;
    window_report_t   window_reports_q[$];
    int               errors;

    function new();
      cwnd     = WIN_ONE;
      ssthresh = INIT_THR;
      ph       = PH_SLOW;
      base     = '0;
      dup_cnt  = '0;
      gap_pos  = '0;
      errors   = 0;
    endfunction

    // a threshold write reloads the live threshold as well
    function void load_threshold(logic [THR_W-1:0] v);
      ssthresh = v;
    endfunction

    function int pending();
      return window_reports_q.size();
    endfunction

    function logic [WIN_W-1:0] clamp_window(logic [63:0] v);
      return (v > 64'(WIN_MAX)) ? WIN_MAX : v[WIN_W-1:0];
    endfunction

    function logic [THR_W-1:0] half_window();
      logic [63:0] h;
      h = 64'(cwnd) >> (FRACTION_BITS + 1);
      return (h > 64'(THR_MAX)) ? THR_MAX : h[THR_W-1:0];
    endfunction

    function void note_input(ack_item_t it);
      window_report_t r;
      logic [63:0]    step;
      r = '0;
      if (it.req_type == REQ_TIMEOUT) begin
        ssthresh           = half_window();
        cwnd               = WIN_ONE;
        dup_cnt            = '0;
        ph                 = PH_SLOW;
        r.retransmit       = 1'b1;
        r.retransmit_first = base;
        r.retransmit_last  = gap_pos;
      end else if (it.header_valid) begin
        if (it.ack_number > base) begin
          r.ack_was_new = 1'b1;
          base          = base + SEQ_W'(1);
          dup_cnt       = '0;
          case (ph)
            PH_SLOW: begin
              cwnd = clamp_window(64'(cwnd) + 64'(WIN_ONE));
              if (64'(cwnd) >= (64'(ssthresh) << FRACTION_BITS)) ph = PH_AVOID;
            end
            PH_RECOV: begin
              cwnd = clamp_window(64'(ssthresh) << FRACTION_BITS);
              ph   = PH_AVOID;
            end
            default: begin
              // 1/window in q format, zero window gives the saturated step
              if (cwnd == '0) begin
                step = 64'(WIN_MAX);
              end else begin
                step = (64'd1 << (2 * FRACTION_BITS)) / 64'(cwnd);
              end
              cwnd = clamp_window(64'(cwnd) + step);
            end
          endcase
        end else if (ph == PH_RECOV) begin
          cwnd = clamp_window(64'(cwnd) + 64'(WIN_ONE));
        end else begin
          gap_pos = it.seq_number;
          if (dup_cnt < DUP_LIMIT) dup_cnt++;
          if (dup_cnt == DUP_LIMIT) begin
            ssthresh           = half_window();
            cwnd               = clamp_window((64'(ssthresh) + 64'(THR_FAST)) << FRACTION_BITS);
            ph                 = PH_RECOV;
            r.retransmit       = 1'b1;
            r.retransmit_first = base;
            r.retransmit_last  = gap_pos;
          end
        end
      end
      r.window_q8       = cwnd;
      r.threshold       = ssthresh;
      r.phase           = ph;
      r.window_base     = base;
      r.duplicate_count = dup_cnt;
      window_reports_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_result(window_report_t got);
      window_report_t want;
      if (window_reports_q.size() == 0) begin
        report("result transaction with nothing outstanding");
        return;
      end
      want = window_reports_q.pop_front();
      compare_field("window_q8", got.window_q8, want.window_q8);
      compare_field("threshold", got.threshold, want.threshold);
      compare_field("phase", got.phase, want.phase);
      compare_field("window_base", got.window_base, want.window_base);
      compare_field("duplicate_count", got.duplicate_count, want.duplicate_count);
      compare_field("retransmit", got.retransmit, want.retransmit);
      compare_field("retransmit_first", got.retransmit_first, want.retransmit_first);
      compare_field("retransmit_last", got.retransmit_last, want.retransmit_last);
      compare_field("ack_was_new", got.ack_was_new, want.ack_was_new);
    endtask
  endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: drives acknowledgement and timeout transactions into the reno window core
// depends on rcwc_pkg, rcwc_in_if, rcwc_out_if, rcwc_scoreboard_pkg and the core itself

module tb_top;
  import rcwc_pkg::*;
  import rcwc_scoreboard_pkg::*;

  // limit sized for every item at its slowest: through the divider, a full gap and a full stall
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 150;
  localparam int MAX_IDLE      = 14;
  localparam int SETTLE_CYCLES = 30;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  rcwc_in_if  in_ch();
  rcwc_out_if out_ch();

  window_scoreboard sb = new();

  // calm stretches: neither side idles
  bit calm    = 1'b0;
  int cycles  = 0;
  // duplicate acks still owed by the current burst
  int dup_run = 0;

  reno_congestion_window_control_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // watchdog, a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic ack_item_t ack_item(logic req, logic [SEQ_W-1:0] ack,
                                         logic [SEQ_W-1:0] seq, logic hv);
    ack_item_t it;
    it.req_type     = req;
    it.ack_number   = ack;
    it.seq_number   = seq;
    it.header_valid = hv;
    return it;
  endfunction

  // mostly well-formed traffic: new acks, bursts of duplicates, some reaching
  // fast recovery, timeouts, plus bad headers and pure noise
  function automatic ack_item_t next_ack_item();
    ack_item_t it;
    int        pick;
    it.req_type     = REQ_ACK;
    it.header_valid = 1'b1;
    it.ack_number   = '0;
    it.seq_number   = SEQ_W'($urandom_range(0, 65535));
    if (dup_run == 0) begin
      pick = $urandom_range(0, 99);
      if (pick >= 45 && pick < 70) dup_run = $urandom_range(1, 5);
    end else begin
      pick = 50;
    end
    if (dup_run > 0) begin
      // ack at or below the base; seq sometimes below it for an empty range
      dup_run--;
      it.ack_number = SEQ_W'($urandom_range(0, sb.base));
      if ($urandom_range(0, 1)) it.seq_number = SEQ_W'($urandom_range(0, sb.base));
    end else if (pick < 45 && sb.base != '1) begin
      if ($urandom_range(0, 1)) begin
        it.ack_number = sb.base + SEQ_W'(1);
      end else begin
        it.ack_number = SEQ_W'($urandom_range(sb.base + 1, 65535));
      end
    end else if (pick < 78) begin
      it.req_type     = REQ_TIMEOUT;
      it.ack_number   = SEQ_W'($urandom_range(0, 65535));
      it.header_valid = 1'($urandom_range(0, 1));
    end else if (pick < 88) begin
      it.header_valid = 1'b0;
      it.ack_number   = SEQ_W'($urandom_range(0, 65535));
    end else begin
      it.req_type     = $urandom_range(0, 1) ? REQ_TIMEOUT : REQ_ACK;
      it.ack_number   = SEQ_W'($urandom_range(0, 65535));
      it.header_valid = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // one input transaction: optional gap, then hold valid until ready
  task automatic send_item(input ack_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.req_type     = it.req_type;
    in_ch.ack_number   = it.ack_number;
    in_ch.seq_number   = it.seq_number;
    in_ch.header_valid = it.header_valid;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_input(it);
  endtask

  // threshold writes only with the core drained
  task automatic load_threshold(input logic [THR_W-1:0] v);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    sb.load_threshold(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result side: random stall before each transaction, sample at the rising edge
  initial begin
    window_report_t seen;
    int             stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      seen.window_q8        = out_ch.window_q8;
      seen.threshold        = out_ch.threshold;
      seen.phase            = phase_t'(out_ch.phase);
      seen.window_base      = out_ch.window_base;
      seen.duplicate_count  = out_ch.duplicate_count;
      seen.retransmit       = out_ch.retransmit;
      seen.retransmit_first = out_ch.retransmit_first;
      seen.retransmit_last  = out_ch.retransmit_last;
      seen.ack_was_new      = out_ch.ack_was_new;
      sb.check_result(seen);
    end
  end

  initial begin
    logic [THR_W-1:0] thr_plan [6];
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_ACK;
    in_ch.ack_number   = '0;
    in_ch.seq_number   = '0;
    in_ch.header_valid = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, default threshold of 10
    // bad header with the largest ack must leave everything alone
    send_item(ack_item(REQ_ACK, 16'hFFFF, 16'hFFFF, 1'b0));
    send_item(ack_item(REQ_ACK, 16'h0001, 16'h0000, 1'b1));
    send_item(ack_item(REQ_ACK, 16'hFFFF, 16'hFFFF, 1'b1));
    // three duplicates, last seq below the base gives an empty resend range
    send_item(ack_item(REQ_ACK, 16'h0000, 16'h1234, 1'b1));
    send_item(ack_item(REQ_ACK, 16'h0002, 16'hFFFF, 1'b1));
    send_item(ack_item(REQ_ACK, 16'h0001, 16'h0001, 1'b1));
    // duplicate inside fast recovery only inflates the window
    send_item(ack_item(REQ_ACK, 16'h0000, 16'h0000, 1'b1));
    // leave recovery, then one avoidance step through the divider
    send_item(ack_item(REQ_ACK, 16'h0003, 16'h0000, 1'b1));
    send_item(ack_item(REQ_ACK, 16'h0004, 16'h0000, 1'b1));
    // two timeouts push the threshold down to zero
    send_item(ack_item(REQ_TIMEOUT, 16'hFFFF, 16'hFFFF, 1'b0));
    send_item(ack_item(REQ_TIMEOUT, 16'h0000, 16'h0000, 1'b1));
    // recovery with zero threshold, new ack then leaves a zero window
    send_item(ack_item(REQ_ACK, 16'h0000, 16'h8000, 1'b1));
    send_item(ack_item(REQ_ACK, 16'h0000, 16'h8000, 1'b1));
    send_item(ack_item(REQ_ACK, 16'h0000, 16'h8000, 1'b1));
    send_item(ack_item(REQ_ACK, 16'h0005, 16'h0000, 1'b1));
    // zero window in avoidance: increment saturates to full scale
    send_item(ack_item(REQ_ACK, 16'h0006, 16'h0000, 1'b1));
    // full window, the divider quotient is zero
    send_item(ack_item(REQ_ACK, 16'hFFFF, 16'h0000, 1'b1));
    // halving a full window gives the largest reachable threshold
    send_item(ack_item(REQ_ACK, 16'h0007, 16'hFFFF, 1'b1));
    send_item(ack_item(REQ_ACK, 16'h0000, 16'hFFFF, 1'b1));
    send_item(ack_item(REQ_ACK, 16'h0007, 16'hFFFF, 1'b1));
    send_item(ack_item(REQ_ACK, 16'h0003, 16'h0000, 1'b1));
    send_item(ack_item(REQ_TIMEOUT, 16'h0000, 16'hFFFF, 1'b1));
    send_item(ack_item(REQ_ACK, 16'h0000, 16'h5555, 1'b0));

    // random phases, each after its own threshold load, extremes included
    thr_plan = '{16'd1, THR_MAX, THR_W'($urandom_range(2, 64)),
                 THR_W'($urandom_range(1, 65535)), 16'd2, INIT_THR};
    for (int p = 0; p < 6; p++) begin
      load_threshold(thr_plan[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        send_item(next_ack_item());
      end
    end

    // drain, then give the core time to show anything unexpected
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- reno_congestion_window_control_core.f -----
src/rcwc_pkg.sv
src/rcwc_in_if.sv
src/rcwc_out_if.sv
src/rcwc_div.sv
src/reno_congestion_window_control_core.sv
verif/rcwc_scoreboard_pkg.sv
verif/tb_top.sv
